@@ rtl/core/baro_sensor_compensation_defines.svh @@
// Assertion helpers shared by the checker.
`ifndef BARO_SENSOR_COMPENSATION_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_DEFINES_SVH

// Same-cycle implication, checked in and out of reset.
`define BSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is held.
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked in and out of reset.
`define BSC_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/bsc_pkg.sv @@
package bsc_pkg;

  localparam int NUM_STAGES = 9;

  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int TEMP_W  = 19;
  localparam int PRESS_W = 32;
  localparam int IDX_W   = 3;

  // 20.00 C and -15.00 C thresholds of the second-order correction
  localparam int TEMP_REF  = 2000;
  localparam int TEMP_COLD = -1500;

  typedef enum logic [IDX_W-1:0] {
    REG_PRESS_SENS  = 3'd0,
    REG_PRESS_OFF   = 3'd1,
    REG_SENS_TCOEF  = 3'd2,
    REG_OFF_TCOEF   = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SLOPE  = 3'd5
  } cfg_reg_t;

endpackage

@@ rtl/core/bsc_pipe_ctrl.sv @@
module bsc_pipe_ctrl #(
  parameter int NumStages = bsc_pkg::NUM_STAGES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [NumStages-1:0] stage_en
);

  logic [NumStages-1:0] vld_r;
  logic [NumStages-1:0] vld_nxt;

  // a stage loads when empty or when its word moves on
  always_comb begin
    stage_en[NumStages-1] = !vld_r[NumStages-1] || out_ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (stage_en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (stage_en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = vld_r[NumStages-1];

endmodule

@@ rtl/core/baro_sensor_compensation.sv @@
// Throughput: one word per cycle while the output is not stalled.
// Nine register stages, each holding one word.
// A stalled output holds its word while empty stages upstream keep filling.
// Reset (rst_n low, synchronous) clears all stage valid bits and sets the six
// calibration registers to zero.
module baro_sensor_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bsc_pkg::RAW_W-1:0]         in_raw_temp_reading,
  input  logic [bsc_pkg::RAW_W-1:0]         in_raw_press_reading,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bsc_pkg::TEMP_W-1:0] out_temperature_centi,
  output logic signed [bsc_pkg::PRESS_W-1:0] out_pressure_centi,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bsc_pkg::IDX_W-1:0]         cfg_index,
  input  logic [bsc_pkg::CAL_W-1:0]         cfg_data
);

  logic [bsc_pkg::NUM_STAGES-1:0] stage_en;

  bsc_pipe_ctrl #(
    .NumStages (bsc_pkg::NUM_STAGES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stage_en  (stage_en)
  );

  // calibration registers
  logic [15:0] psens_r, poff_r, stc_r, otc_r, tref_r, slope_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psens_r <= '0;
      poff_r  <= '0;
      stc_r   <= '0;
      otc_r   <= '0;
      tref_r  <= '0;
      slope_r <= '0;
    end else if (cfg_valid) begin
      case (bsc_pkg::cfg_reg_t'(cfg_index))
        bsc_pkg::REG_PRESS_SENS: psens_r <= cfg_data;
        bsc_pkg::REG_PRESS_OFF:  poff_r  <= cfg_data;
        bsc_pkg::REG_SENS_TCOEF: stc_r   <= cfg_data;
        bsc_pkg::REG_OFF_TCOEF:  otc_r   <= cfg_data;
        bsc_pkg::REG_REF_TEMP:   tref_r  <= cfg_data;
        bsc_pkg::REG_TEMP_SLOPE: slope_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: dt
  logic signed [24:0] s0_dt_r, s0_dt_nxt;
  logic [23:0]        s0_press_r;

  assign s0_dt_nxt = $signed({1'b0, in_raw_temp_reading}) - $signed({1'b0, tref_r, 8'h00});

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      s0_dt_r    <= s0_dt_nxt;
      s0_press_r <= in_raw_press_reading;
    end
  end

  // stage 1: products with dt
  logic signed [41:0] s1_mt_r, s1_mt_nxt, s1_mo_r, s1_mo_nxt, s1_ms_r, s1_ms_nxt;
  logic signed [49:0] s1_dd_r, s1_dd_nxt;
  logic [23:0]        s1_press_r;

  always_comb begin
    s1_mt_nxt = s0_dt_r * $signed({1'b0, slope_r});
    s1_mo_nxt = s0_dt_r * $signed({1'b0, otc_r});
    s1_ms_nxt = s0_dt_r * $signed({1'b0, stc_r});
    s1_dd_nxt = s0_dt_r * s0_dt_r;
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s1_mt_r    <= s1_mt_nxt;
      s1_mo_r    <= s1_mo_nxt;
      s1_ms_r    <= s1_ms_nxt;
      s1_dd_r    <= s1_dd_nxt;
      s1_press_r <= s0_press_r;
    end
  end

  // stage 2: first-order temp, off, sens
  logic [19:0] s2_t20;
  logic [18:0] s2_temp_r, s2_t2_r, s2_t2_nxt;
  logic [36:0] s2_off1_r, s2_off1_nxt;
  logic [35:0] s2_sens1_r, s2_sens1_nxt;
  logic [23:0] s2_press_r;

  always_comb begin
    s2_t20       = 20'(bsc_pkg::TEMP_REF) + {s1_mt_r[41], s1_mt_r[41:23]};
    s2_off1_nxt  = {5'b0, poff_r, 16'b0} + {{2{s1_mo_r[41]}}, s1_mo_r[41:7]};
    s2_sens1_nxt = {5'b0, psens_r, 15'b0} + {{2{s1_ms_r[41]}}, s1_ms_r[41:8]};
    s2_t2_nxt    = s1_dd_r[49:31];
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      s2_temp_r  <= s2_t20[18:0];
      s2_off1_r  <= s2_off1_nxt;
      s2_sens1_r <= s2_sens1_nxt;
      s2_t2_r    <= s2_t2_nxt;
      s2_press_r <= s1_press_r;
    end
  end

  // stage 3: squares of the distances to the two thresholds
  logic [19:0]        s3_d, s3_e;
  logic signed [39:0] s3_dsq_nxt, s3_esq_nxt;
  logic [39:0]        s3_dsq_r, s3_esq_r;
  logic               s3_warm_lo_nxt, s3_cold_nxt, s3_warm_lo_r, s3_cold_r;
  logic [18:0]        s3_temp_r, s3_t2_r;
  logic [36:0]        s3_off1_r;
  logic [35:0]        s3_sens1_r;
  logic [23:0]        s3_press_r;

  always_comb begin
    s3_d           = {s2_temp_r[18], s2_temp_r} - 20'(bsc_pkg::TEMP_REF);
    s3_e           = {s2_temp_r[18], s2_temp_r} - 20'(bsc_pkg::TEMP_COLD);
    s3_dsq_nxt     = $signed(s3_d) * $signed(s3_d);
    s3_esq_nxt     = $signed(s3_e) * $signed(s3_e);
    s3_warm_lo_nxt = $signed(s2_temp_r) < $signed(19'(bsc_pkg::TEMP_REF));
    s3_cold_nxt    = $signed(s2_temp_r) < $signed(19'(bsc_pkg::TEMP_COLD));
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s3_dsq_r     <= s3_dsq_nxt;
      s3_esq_r     <= s3_esq_nxt;
      s3_warm_lo_r <= s3_warm_lo_nxt;
      s3_cold_r    <= s3_cold_nxt;
      s3_temp_r    <= s2_temp_r;
      s3_t2_r      <= s2_t2_r;
      s3_off1_r    <= s2_off1_r;
      s3_sens1_r   <= s2_sens1_r;
      s3_press_r   <= s2_press_r;
    end
  end

  // stage 4: second-order terms, final temperature
  logic [43:0] s4_dsq5, s4_esq7, s4_esq11;
  logic [43:0] s4_off2_r, s4_off2_nxt, s4_sens2_r, s4_sens2_nxt;
  logic [18:0] s4_temp_r, s4_temp_nxt;
  logic        s4_warm_lo_r;
  logic [36:0] s4_off1_r;
  logic [35:0] s4_sens1_r;
  logic [23:0] s4_press_r;

  always_comb begin
    s4_dsq5  = {4'b0, s3_dsq_r} + {2'b0, s3_dsq_r, 2'b0};
    s4_esq7  = {1'b0, s3_esq_r, 3'b0} - {4'b0, s3_esq_r};
    s4_esq11 = {1'b0, s3_esq_r, 3'b0} + {3'b0, s3_esq_r, 1'b0} + {4'b0, s3_esq_r};
    s4_off2_nxt  = (s4_dsq5 >> 1) + (s3_cold_r ? s4_esq7 : 44'd0);
    s4_sens2_nxt = (s4_dsq5 >> 2) + (s3_cold_r ? (s4_esq11 >> 1) : 44'd0);
    s4_temp_nxt  = s3_warm_lo_r ? (s3_temp_r - s3_t2_r) : s3_temp_r;
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      s4_off2_r    <= s4_off2_nxt;
      s4_sens2_r   <= s4_sens2_nxt;
      s4_temp_r    <= s4_temp_nxt;
      s4_warm_lo_r <= s3_warm_lo_r;
      s4_off1_r    <= s3_off1_r;
      s4_sens1_r   <= s3_sens1_r;
      s4_press_r   <= s3_press_r;
    end
  end

  // stage 5: apply second-order correction to off and sens
  logic [41:0] s5_off_r, s5_off_nxt, s5_sens_r, s5_sens_nxt;
  logic [18:0] s5_temp_r;
  logic [23:0] s5_press_r;

  always_comb begin
    s5_off_nxt  = {{5{s4_off1_r[36]}}, s4_off1_r};
    s5_sens_nxt = {{6{s4_sens1_r[35]}}, s4_sens1_r};
    if (s4_warm_lo_r) begin
      s5_off_nxt  = s5_off_nxt - s4_off2_r[41:0];
      s5_sens_nxt = s5_sens_nxt - s4_sens2_r[41:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      s5_off_r   <= s5_off_nxt;
      s5_sens_r  <= s5_sens_nxt;
      s5_temp_r  <= s4_temp_r;
      s5_press_r <= s4_press_r;
    end
  end

  // stage 6: raw pressure times sens, split into two partial products
  logic [43:0]        s6_plo_r, s6_plo_nxt;
  logic signed [46:0] s6_phi_r, s6_phi_nxt;
  logic [41:0]        s6_off_r;
  logic [18:0]        s6_temp_r;

  always_comb begin
    s6_plo_nxt = s5_press_r * s5_sens_r[19:0];
    s6_phi_nxt = $signed({1'b0, s5_press_r}) * $signed(s5_sens_r[41:20]);
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      s6_plo_r  <= s6_plo_nxt;
      s6_phi_r  <= s6_phi_nxt;
      s6_off_r  <= s5_off_r;
      s6_temp_r <= s5_temp_r;
    end
  end

  // stage 7: combine partial products
  logic [67:0] s7_sum_r, s7_sum_nxt;
  logic [41:0] s7_off_r;
  logic [18:0] s7_temp_r;

  assign s7_sum_nxt = {s6_phi_r[46], s6_phi_r, 20'b0} + {24'b0, s6_plo_r};

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      s7_sum_r  <= s7_sum_nxt;
      s7_off_r  <= s6_off_r;
      s7_temp_r <= s6_temp_r;
    end
  end

  // stage 8: output register
  logic [47:0] s8_diff;
  logic [31:0] s8_press_r;
  logic [18:0] s8_temp_r;

  assign s8_diff = {s7_sum_r[67], s7_sum_r[67:21]} - {{6{s7_off_r[41]}}, s7_off_r};

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      s8_press_r <= s8_diff[46:15];
      s8_temp_r  <= s7_temp_r;
    end
  end

  assign out_temperature_centi = $signed(s8_temp_r);
  assign out_pressure_centi    = $signed(s8_press_r);

endmodule

@@ rtl/core/bsc_checker.sv @@
`include "baro_sensor_compensation_defines.svh"

module bsc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [bsc_pkg::TEMP_W-1:0]  out_temperature_centi,
  input logic signed [bsc_pkg::PRESS_W-1:0] out_pressure_centi
);

  // reset empties the pipeline
  `BSC_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid, "output valid after reset")

  // a draining output never blocks the input side
  `BSC_ASSERT_NOW(a_ready_flow, out_ready, in_ready, "input blocked while output drains")

  // input only backs up when every stage is full behind a stalled output
  `BSC_ASSERT_NOW(a_full_stall, !in_ready, out_valid && !out_ready,
                  "input blocked without output stall")

  // a stalled result word holds
  `BSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_temperature_centi) && $stable(out_pressure_centi),
                   "stalled output word changed")

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);
